>>> hdl/swfa_pkg.sv
// Shared types and constants for the sync word frame aligner.
// Used by every module of the block; depends on nothing.
package swfa_pkg;

    localparam int SYNC_PAT_W   = 32;
    localparam int SYNC_LEN_W   = 6;
    localparam int MAX_RESULTS  = 3;
    localparam int RUN_CNT_W    = 2;
    localparam int CFG_IDX_W    = 3;
    localparam int CFG_DATA_W   = 32;

    localparam logic [SYNC_PAT_W-1:0] RST_SYNC_PATTERN  = 32'd487184;
    localparam logic [SYNC_LEN_W-1:0] RST_SYNC_LENGTH   = 6'd19;
    localparam logic [7:0]            RST_FRAME_BYTES   = 8'd104;
    localparam logic [7:0]            RST_HEADER_FIRST  = 8'b11101101;
    localparam logic [7:0]            RST_HEADER_SECOND = 8'b11100010;

    // Bits of the first data byte already taken by the sync word tail
    localparam logic [2:0] FIRST_BIT_COUNT = 3'd3;
    localparam logic [2:0] LAST_BIT_COUNT  = 3'd7;
    localparam logic [7:0] HEADER0_POS     = 8'd0;
    localparam logic [7:0] HEADER1_POS     = 8'd1;
    localparam logic [7:0] FIRST_DATA_POS  = 8'd2;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SYNC_PATTERN  = 3'd0,
        CFG_SYNC_LENGTH   = 3'd1,
        CFG_FRAME_BYTES   = 3'd2,
        CFG_HEADER_FIRST  = 3'd3,
        CFG_HEADER_SECOND = 3'd4
    } cfg_idx_e;

    typedef struct packed {
        logic [SYNC_PAT_W-1:0] sync_pattern;
        logic [SYNC_LEN_W-1:0] sync_length;
        logic [7:0]            frame_bytes;
        logic [7:0]            header_first;
        logic [7:0]            header_second;
    } cfg_t;

    typedef struct packed {
        logic        bit_in;
        logic [31:0] time_tag;
    } in_item_t;

    typedef struct packed {
        logic [7:0]  data_byte;
        logic [7:0]  byte_index;
        logic [31:0] frame_time;
        logic        inverted;
        logic        frame_end;
        logic [15:0] frame_count;
        logic        run_last;
    } out_item_t;

    // All results caused by one input bit, oldest in item[0]
    typedef struct packed {
        out_item_t [MAX_RESULTS-1:0] item;
        logic [RUN_CNT_W-1:0]        count;
    } run_t;

endpackage

>>> hdl/swfa_cfg.sv
// Configuration register file of the sync word frame aligner.
// Depends on swfa_pkg for the register index codes and the cfg_t bundle.
module swfa_cfg
    import swfa_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    output cfg_t                  cfg
);

    cfg_t cfg_reg;
    cfg_t cfg_next;

    assign cfg_ready = 1'b1;
    assign cfg      = cfg_reg;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_valid) begin
            unique case (cfg_idx_e'(cfg_index))
                CFG_SYNC_PATTERN:  cfg_next.sync_pattern  = cfg_data[SYNC_PAT_W-1:0];
                CFG_SYNC_LENGTH:   cfg_next.sync_length   = cfg_data[SYNC_LEN_W-1:0];
                CFG_FRAME_BYTES:   cfg_next.frame_bytes   = cfg_data[7:0];
                CFG_HEADER_FIRST:  cfg_next.header_first  = cfg_data[7:0];
                CFG_HEADER_SECOND: cfg_next.header_second = cfg_data[7:0];
                default:           cfg_next = cfg_reg;  // drop unknown index
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.sync_pattern  <= RST_SYNC_PATTERN;
            cfg_reg.sync_length   <= RST_SYNC_LENGTH;
            cfg_reg.frame_bytes   <= RST_FRAME_BYTES;
            cfg_reg.header_first  <= RST_HEADER_FIRST;
            cfg_reg.header_second <= RST_HEADER_SECOND;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

>>> hdl/swfa_core.sv
// Input register, sync correlator and byte packer of the frame aligner.
// Depends on swfa_pkg; produces one run of up to three results per bit.
module swfa_core
    import swfa_pkg::*;
#(
    parameter int MAX_SYNC_BITS = 32
) (
    input  logic     aclk,
    input  logic     aresetn,
    input  cfg_t     cfg,
    input  logic     s_valid,
    output logic     s_ready,
    input  in_item_t s_data,
    output logic     run_valid,
    input  logic     run_ready,
    output run_t     run
);

    localparam int FW = $clog2(MAX_SYNC_BITS + 1);
    localparam int CW = (FW > SYNC_LEN_W) ? FW : SYNC_LEN_W;

    logic                     in_valid_reg;
    in_item_t                 in_reg;
    logic                     advance;

    logic [MAX_SYNC_BITS-1:0] hist_reg, hist_next;
    logic [FW-1:0]            fill_reg, fill_next;
    logic                     in_frame_reg, in_frame_next;
    logic                     pol_reg, pol_next;
    logic [2:0]               bcnt_reg, bcnt_next;
    logic [7:0]               acc_reg, acc_next;
    logic [7:0]               bpos_reg, bpos_next;
    logic [15:0]              frames_reg, frames_next;

    logic [CW-1:0]            len_raw, len_eff;
    logic [MAX_SYNC_BITS-1:0] len_mask, pat_ext, diff;
    logic                     hit_norm, hit_inv, sync_hit;
    logic                     byte_done, frame_done;
    logic [7:0]               acc_shift, bpos_inc;
    out_item_t                data_item, hdr0_item, hdr1_item;
    run_t                     run_c;

    // Effective sync length: zero means one, clamp to history depth
    assign len_raw = CW'(cfg.sync_length);
    always_comb begin
        if (len_raw == '0)
            len_eff = CW'(1);
        else if (len_raw > CW'(MAX_SYNC_BITS))
            len_eff = CW'(MAX_SYNC_BITS);
        else
            len_eff = len_raw;
        for (int i = 0; i < MAX_SYNC_BITS; i++) begin
            len_mask[i] = (CW'(i) < len_eff);
        end
    end

    // Byte packer for the open frame
    assign acc_shift  = {acc_reg[6:0], in_reg.bit_in ^ pol_reg};
    assign bpos_inc   = bpos_reg + 8'd1;
    assign byte_done  = in_frame_reg && (bcnt_reg == LAST_BIT_COUNT);
    assign frame_done = byte_done &&
                        ((bpos_inc >= cfg.frame_bytes) || (bpos_inc == 8'd0));

    // History shift and correlation against the pattern and its inverse
    assign hist_next = {hist_reg[MAX_SYNC_BITS-2:0], in_reg.bit_in};
    assign fill_next = (fill_reg < FW'(MAX_SYNC_BITS)) ? fill_reg + FW'(1) : fill_reg;
    assign pat_ext   = MAX_SYNC_BITS'(cfg.sync_pattern);
    assign diff      = hist_next ^ pat_ext;
    assign hit_norm  = ((diff & len_mask) == '0);
    assign hit_inv   = ((~diff & len_mask) == '0);
    assign sync_hit  = (!in_frame_reg || frame_done) && (CW'(fill_next) >= len_eff) &&
                       (hit_norm || hit_inv);

    always_comb begin
        data_item             = '0;
        data_item.data_byte   = acc_shift;
        data_item.byte_index  = bpos_reg;
        data_item.inverted    = pol_reg;
        data_item.frame_end   = frame_done;
        data_item.frame_count = frames_reg;

        hdr0_item             = '0;
        hdr0_item.data_byte   = cfg.header_first;
        hdr0_item.byte_index  = HEADER0_POS;
        hdr0_item.frame_time  = in_reg.time_tag;
        hdr0_item.inverted    = !hit_norm;
        hdr0_item.frame_count = frames_reg + 16'd1;

        hdr1_item             = hdr0_item;
        hdr1_item.data_byte   = cfg.header_second;
        hdr1_item.byte_index  = HEADER1_POS;
        hdr1_item.run_last    = 1'b1;

        run_c = '0;
        if (byte_done && sync_hit) begin
            run_c.item[0] = data_item;
            run_c.item[1] = hdr0_item;
            run_c.item[2] = hdr1_item;
            run_c.count   = RUN_CNT_W'(3);
        end else if (sync_hit) begin
            run_c.item[0] = hdr0_item;
            run_c.item[1] = hdr1_item;
            run_c.count   = RUN_CNT_W'(2);
        end else if (byte_done) begin
            run_c.item[0]          = data_item;
            run_c.item[0].run_last = 1'b1;
            run_c.count            = RUN_CNT_W'(1);
        end
    end

    // Next state of the frame tracker
    always_comb begin
        in_frame_next = in_frame_reg;
        pol_next      = pol_reg;
        bcnt_next     = bcnt_reg;
        acc_next      = acc_reg;
        bpos_next     = bpos_reg;
        frames_next   = frames_reg;
        if (in_frame_reg) begin
            if (byte_done) begin
                bcnt_next = '0;
                acc_next  = '0;
                bpos_next = bpos_inc;
                if (frame_done)
                    in_frame_next = 1'b0;
            end else begin
                bcnt_next = bcnt_reg + 3'd1;
                acc_next  = acc_shift;
            end
        end
        if (sync_hit) begin
            frames_next   = frames_reg + 16'd1;
            pol_next      = !hit_norm;
            in_frame_next = 1'b1;
            bpos_next     = FIRST_DATA_POS;
            bcnt_next     = FIRST_BIT_COUNT;
            acc_next      = '0;
        end
    end

    assign run_valid = in_valid_reg && (run_c.count != '0);
    assign run       = run_c;
    assign advance   = in_valid_reg && ((run_c.count == '0) || run_ready);
    assign s_ready   = !in_valid_reg || advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_reg <= s_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hist_reg     <= '0;
            fill_reg     <= '0;
            in_frame_reg <= 1'b0;
            pol_reg      <= 1'b0;
            bcnt_reg     <= '0;
            acc_reg      <= '0;
            bpos_reg     <= '0;
            frames_reg   <= '0;
        end else if (advance) begin
            hist_reg     <= hist_next;
            fill_reg     <= fill_next;
            in_frame_reg <= in_frame_next;
            pol_reg      <= pol_next;
            bcnt_reg     <= bcnt_next;
            acc_reg      <= acc_next;
            bpos_reg     <= bpos_next;
            frames_reg   <= frames_next;
        end
    end

endmodule

>>> hdl/swfa_out.sv
// Result register of the frame aligner: holds one run, hands it out item by item.
// Depends on swfa_pkg for run_t and out_item_t.
module swfa_out
    import swfa_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      run_valid,
    output logic      run_ready,
    input  run_t      run,
    output logic      m_valid,
    input  logic      m_ready,
    output out_item_t m_data
);

    logic                 valid_reg;
    run_t                 run_reg;
    logic [RUN_CNT_W-1:0] rd_reg;
    logic                 last;

    assign m_valid   = valid_reg;
    assign m_data    = run_reg.item[rd_reg];
    assign last      = run_reg.item[rd_reg].run_last;
    assign run_ready = !valid_reg || (m_ready && last);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
            rd_reg    <= '0;
        end else if (run_valid && run_ready) begin
            valid_reg <= 1'b1;
            rd_reg    <= '0;
        end else if (valid_reg && m_ready) begin
            if (last)
                valid_reg <= 1'b0;
            else
                rd_reg <= rd_reg + RUN_CNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (run_valid && run_ready) begin
            run_reg <= run;
        end
    end

endmodule

>>> hdl/sync_word_frame_aligner.sv
// Top level of the sync word frame aligner.
// Depends on swfa_pkg, swfa_cfg, swfa_core and swfa_out.
//
// Usage:
//   s_* channel: one demodulated bit per transaction with its time tag.
//   m_* channel: one byte per transaction. On a sync word match (normal or
//   inverted) the two header bytes come out, both carrying the time tag
//   of the bit that completed sync; then every eight received bits give one
//   frame byte (the first after five) until frame_bytes bytes are out.
//   run_last marks the last result caused by one input bit.
//   cfg_* channel: register writes, always ready, index order is sync_pattern,
//   sync_length, frame_bytes, header_first, header_second. Write only while idle.
// Path: a bit accepted into the input register is evaluated there, and its
//   first result is registered in the result register, then shown on m_*.
// Throughput: one bit per cycle while the result register is free. A sync
//   burst of two or three results holds it until the last result is taken;
//   a bit with no result still passes, one with a result waits and drops s_ready.
// Reset (aresetn low, synchronous): history, frame tracker and frame counter
//   clear, registers return to defaults, both valids drop.
// Receiver stall: the result register holds; bits that cause no result keep
//   flowing, and the first one that causes a result waits in the input
//   register with s_ready low, so back-pressure reaches the sender.
module sync_word_frame_aligner
    import swfa_pkg::*;
#(
    parameter int MAX_SYNC_BITS = 32
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  in_item_t              s_data,
    output logic                  m_valid,
    input  logic                  m_ready,
    output out_item_t             m_data,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    cfg_t cfg;
    logic run_valid;
    logic run_ready;
    run_t run;

    // Configuration registers
    swfa_cfg u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    // Correlate, pack and advance the frame state, one bit per transaction
    swfa_core #(
        .MAX_SYNC_BITS (MAX_SYNC_BITS)
    ) u_core (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg       (cfg),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .run_valid (run_valid),
        .run_ready (run_ready),
        .run       (run)
    );

    // Hold the run and hand it out one byte per transaction
    swfa_out u_out (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .run_valid (run_valid),
        .run_ready (run_ready),
        .run       (run),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

endmodule

>>> hdl/swfa_checker.sv
// Port-level checks for the sync word frame aligner, bound to the top level.
// Depends on swfa_pkg and sync_word_frame_aligner.
module swfa_port_sva
    import swfa_pkg::*;
(
    input logic      aclk,
    input logic      aresetn,
    input logic      m_valid,
    input logic      m_ready,
    input out_item_t m_data
);

    // Stalled result holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result changed while stalled");

    // First header is followed at once by the second of the same frame
    a_hdr_pair: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_ready && (m_data.byte_index == HEADER0_POS) && !m_data.run_last
        |=> m_valid && (m_data.byte_index == HEADER1_POS) &&
            $stable(m_data.frame_time) && $stable(m_data.frame_count))
        else $error("header pair broken");

    // Second header closes its run and never ends a frame
    a_hdr1_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_data.byte_index == HEADER1_POS) |->
            m_data.run_last && !m_data.frame_end)
        else $error("second header flags wrong");

    // Data bytes carry no time tag; frame end only on data bytes
    a_frame_end: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.frame_end |->
            (m_data.frame_time == 32'd0) && (m_data.byte_index >= FIRST_DATA_POS))
        else $error("frame end on header");

    // Reset empties the output
    a_reset: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("output valid after reset");

endmodule

bind sync_word_frame_aligner swfa_port_sva u_swfa_port_sva (
    .aclk    (aclk),
    .aresetn (aresetn),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);
